// ===== hdl/cbd_pkg.sv =====
`default_nettype none

package cbd_pkg;

	// Queue geometry.
	localparam int DEPTH = 1024;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Field widths of the words on the two channels.
	localparam int WORD_W = 32;
	localparam int MODE_W = 3;
	localparam int STAT_W = 2;
	localparam int OCC_W = 11;

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PEEK_BACK = 3'd5;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd6;

	// Status codes.
	localparam logic [STAT_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

	// Request word.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic signed [WORD_W-1:0] push_value;
	} cbd_req_t;

	// Response word.
	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0] occupancy;
		logic is_full;
		logic is_empty;
	} cbd_rsp_t;

	// Controller state.
	typedef enum logic {
		ST_IDLE,
		ST_READ
	} cbd_state_t;

	// Result handed from the controller to the output register.
	typedef struct packed {
		logic load;
		cbd_rsp_t rsp;
	} cbd_res_t;

	// Circular index steps.
	function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/circular_buffer_deque.sv =====
// Double-ended queue in a circular single-port-write, single-port-read memory.
// Push, clear and error results are written to the output register on acceptance;
// pop and peek results pass the memory read register and ST_READ first.
// Throughput: one word per cycle for push and clear while the output drains;
// pop and peek take no new request while their memory read is in flight.
// Reset: arst_n resets indices (front 1, back 0) and count at once; memory contents stay undefined.
`default_nettype none

module circular_buffer_deque
	import cbd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire cbd_req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output cbd_rsp_t rsp
);

	logic idle;
	logic req_fire;
	logic mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;
	cbd_res_t res;
	logic out_valid_q;
	cbd_rsp_t out_q;

	// A new word is taken while the controller is idle and the output slot is free or drains this cycle.
	assign req_ready = idle && (!out_valid_q || rsp_ready);
	assign req_fire = req_valid && req_ready;

	cbd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_fire(req_fire),
		.req(req),
		.idle(idle),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res(res)
	);

	cbd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res.load) begin
			out_q <= res.rsp;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule

`default_nettype wire

// ===== hdl/cbd_ram.sv =====
`default_nettype none

module cbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/cbd_ctrl.sv =====
`default_nettype none

module cbd_ctrl
	import cbd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_fire,
	input wire cbd_req_t req,
	output logic idle,
	output logic mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output logic [WORD_W-1:0] mem_wdata,
	output logic mem_re,
	output logic [IDX_W-1:0] mem_raddr,
	input wire logic [WORD_W-1:0] mem_rdata,
	output cbd_res_t res
);

	cbd_state_t state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [IDX_W-1:0] back_q, back_d;
	logic [CNT_W-1:0] count_q, count_d;
	cbd_rsp_t pend_q, rsp_now;
	logic full, empty;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= IDX_W'(1);
			back_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			back_q <= back_d;
			count_q <= count_d;
		end
	end

	// Response fields held while the memory read is in flight.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			pend_q <= rsp_now;
		end
	end

	// Decode the operation, update indices and count, and drive the memory.
	always_comb begin
		state_d = state_q;
		front_d = front_q;
		back_d = back_q;
		count_d = count_q;
		mem_we = 1'b0;
		mem_waddr = front_q;
		mem_wdata = req.push_value;
		mem_re = 1'b0;
		mem_raddr = front_q;
		rsp_now = '0;
		rsp_now.status = STATUS_OK;
		res = '0;
		idle = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req.mode)
						MODE_PUSH_FRONT: begin
							if (full) begin
								rsp_now.status = STATUS_FULL;
							end else begin
								front_d = step_down(front_q);
								mem_we = 1'b1;
								mem_waddr = front_d;
								count_d = count_q + CNT_W'(1);
							end
						end
						MODE_PUSH_BACK: begin
							if (full) begin
								rsp_now.status = STATUS_FULL;
							end else begin
								back_d = step_up(back_q);
								mem_we = 1'b1;
								mem_waddr = back_d;
								count_d = count_q + CNT_W'(1);
							end
						end
						MODE_POP_FRONT: begin
							if (empty) begin
								rsp_now.status = STATUS_EMPTY;
							end else begin
								mem_re = 1'b1;
								mem_raddr = front_q;
								front_d = step_up(front_q);
								count_d = count_q - CNT_W'(1);
							end
						end
						MODE_POP_BACK: begin
							if (empty) begin
								rsp_now.status = STATUS_EMPTY;
							end else begin
								mem_re = 1'b1;
								mem_raddr = back_q;
								back_d = step_down(back_q);
								count_d = count_q - CNT_W'(1);
							end
						end
						MODE_PEEK_FRONT: begin
							if (empty) begin
								rsp_now.status = STATUS_EMPTY;
							end else begin
								mem_re = 1'b1;
								mem_raddr = front_q;
							end
						end
						MODE_PEEK_BACK: begin
							if (empty) begin
								rsp_now.status = STATUS_EMPTY;
							end else begin
								mem_re = 1'b1;
								mem_raddr = back_q;
							end
						end
						MODE_CLEAR: begin
							front_d = IDX_W'(1);
							back_d = '0;
							count_d = '0;
						end
						default: begin
						end
					endcase

					rsp_now.occupancy = OCC_W'(count_d);
					rsp_now.is_full = (count_d == CNT_W'(DEPTH));
					rsp_now.is_empty = (count_d == '0);

					// Reads finish next cycle; everything else answers at once.
					if (mem_re) begin
						state_d = ST_READ;
					end else begin
						res.load = 1'b1;
						res.rsp = rsp_now;
					end
				end
			end
			ST_READ: begin
				res.load = 1'b1;
				res.rsp = pend_q;
				res.rsp.read_value = mem_rdata;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
